// ----- rtl/core/sra_pkg.sv -----
`timescale 1ns / 1ps

package sra_pkg;

   localparam int NUM_SECTORS = 4096;
   localparam int RUN_LENGTH  = 8;

   localparam int WORD_W = 64;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int ROWS   = (NUM_SECTORS + WORD_W - 1) / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SIDX_W = ROW_W + BIT_W;

   localparam int DEV_W  = 13;
   localparam int IDX_W  = 12;
   localparam int STAT_W = 2;
   localparam int LIM_W  = ((SIDX_W > DEV_W) ? SIDX_W : DEV_W) + 1;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_RUN  = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [2*WORD_W-1:0] RUN_ONES =
      {{(2*WORD_W-RUN_LENGTH){1'b0}}, {RUN_LENGTH{1'b1}}};

   typedef struct packed {
      logic              we;
      logic [ROW_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ROW_W-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  index;
   } result_type;

endpackage

// ----- rtl/core/sra_bitmap_ram.sv -----
`timescale 1ns / 1ps

module sra_bitmap_ram (
   input  logic                       clock,
   input  sra_pkg::ram_req_type       ram_req,
   output logic [sra_pkg::WORD_W-1:0] rd_data
);
   import sra_pkg::*;

   logic [WORD_W-1:0] mem [ROWS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sra_ctrl.sv -----
`timescale 1ns / 1ps

module sra_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [sra_pkg::LIM_W-1:0]  limit,
   input  logic                       req_valid,
   input  logic                       req_func,
   input  logic [sra_pkg::IDX_W-1:0]  req_index,
   output logic                       req_ready,
   input  logic                       slot_free,
   output sra_pkg::result_type        result,
   output sra_pkg::ram_req_type       ram_req,
   input  logic [sra_pkg::WORD_W-1:0] rd_data
);
   import sra_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_AMASK = 4'd3;
   localparam logic [3:0] S_FCHK0 = 4'd4;
   localparam logic [3:0] S_FCHK1 = 4'd5;
   localparam logic [3:0] S_WRLO  = 4'd6;
   localparam logic [3:0] S_WRHI  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  func_ff, func_in;
   logic [RUN_LENGTH-1:0] tail_ff, tail_in;
   logic [WORD_W-1:0]     lo_ff, lo_in;
   logic [WORD_W-1:0]     hi_ff, hi_in;
   logic [2*WORD_W-1:0]   mask_ff, mask_in;
   logic [BIT_W-1:0]      pos_ff, pos_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [IDX_W-1:0]      index_ff, index_in;

   logic [WORD_W+RUN_LENGTH-1:0] ext;
   logic [WORD_W-1:0]            hit_vec;
   logic                         hit;
   logic [BIT_W-1:0]             hit_pos;
   logic [SIDX_W-1:0]            start;
   logic [LIM_W-1:0]             next_base;
   logic [SIDX_W-1:0]            free_sidx;
   logic                         free_bad;
   logic [WORD_W-1:0]            mask_lo, mask_hi;

   assign mask_lo = mask_ff[WORD_W-1:0];
   assign mask_hi = mask_ff[2*WORD_W-1:WORD_W];

   always_comb begin
      ext = {~rd_data, tail_ff};
      for (int j = 0; j < WORD_W; j++) begin
         hit_vec[j] = (&ext[j+1 +: RUN_LENGTH]) &&
                      (LIM_W'({row_ff, BIT_W'(j)}) < limit);
      end
      hit     = 1'b0;
      hit_pos = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit     = 1'b1;
            hit_pos = BIT_W'(j);
         end
      end
      start     = {row_ff, hit_pos} - SIDX_W'(RUN_LENGTH - 1);
      next_base = LIM_W'({row_ff, BIT_W'(0)}) + LIM_W'(WORD_W);
      free_sidx = SIDX_W'(req_index);
      free_bad  = (LIM_W'(req_index) + LIM_W'(RUN_LENGTH)) > limit;
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      func_in   = func_ff;
      tail_in   = tail_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mask_in   = mask_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      index_in  = index_ff;
      ram_req   = '0;
      result    = '0;
      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = row_ff;
            ram_req.wdata = '0;
            row_in        = row_ff + ROW_W'(1);
            if (row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               status_in = ST_OK;
               index_in  = '0;
               if (req_func == FUNC_ALLOC) begin
                  row_in        = '0;
                  tail_in       = '0;
                  ram_req.re    = 1'b1;
                  ram_req.raddr = '0;
                  state_in      = S_ACHK;
               end else if (free_bad) begin
                  status_in = ST_BAD_RUN;
                  state_in  = S_RESP;
               end else begin
                  row_in        = free_sidx[SIDX_W-1:BIT_W];
                  mask_in       = RUN_ONES << (BIT_W + 1)'(free_sidx[BIT_W-1:0]);
                  ram_req.re    = 1'b1;
                  ram_req.raddr = free_sidx[SIDX_W-1:BIT_W];
                  state_in      = S_FCHK0;
               end
            end
         end
         S_ACHK: begin
            if (hit) begin
               hi_in    = rd_data;
               pos_in   = hit_pos;
               index_in = IDX_W'(start);
               row_in   = row_ff - ROW_W'(1);
               state_in = S_AMASK;
            end else if (row_ff == ROW_W'(ROWS - 1) || next_base >= limit) begin
               status_in = ST_NO_SPACE;
               state_in  = S_RESP;
            end else begin
               lo_in         = rd_data;
               tail_in       = ~rd_data[WORD_W-1 -: RUN_LENGTH];
               row_in        = row_ff + ROW_W'(1);
               ram_req.re    = 1'b1;
               ram_req.raddr = row_ff + ROW_W'(1);
            end
         end
         S_AMASK: begin
            mask_in  = RUN_ONES << ((BIT_W + 1)'(pos_ff) +
                                    (BIT_W + 1)'(WORD_W + 1 - RUN_LENGTH));
            state_in = S_WRLO;
         end
         S_FCHK0: begin
            lo_in = rd_data;
            if ((rd_data & mask_lo) != mask_lo) begin
               status_in = ST_BAD_RUN;
               state_in  = S_RESP;
            end else if (mask_hi != '0) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = row_ff + ROW_W'(1);
               state_in      = S_FCHK1;
            end else begin
               state_in = S_WRLO;
            end
         end
         S_FCHK1: begin
            hi_in = rd_data;
            if ((rd_data & mask_hi) != mask_hi) begin
               status_in = ST_BAD_RUN;
               state_in  = S_RESP;
            end else begin
               state_in = S_WRLO;
            end
         end
         S_WRLO: begin
            ram_req.we    = (mask_lo != '0);
            ram_req.waddr = row_ff;
            ram_req.wdata = (func_ff == FUNC_FREE) ? (lo_ff & ~mask_lo) : (lo_ff | mask_lo);
            state_in      = S_WRHI;
         end
         S_WRHI: begin
            ram_req.we    = (mask_hi != '0);
            ram_req.waddr = row_ff + ROW_W'(1);
            ram_req.wdata = (func_ff == FUNC_FREE) ? (hi_ff & ~mask_hi) : (hi_ff | mask_hi);
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               result.valid  = 1'b1;
               result.status = status_ff;
               result.index  = index_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
      func_ff   <= func_in;
      tail_ff   <= tail_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mask_ff   <= mask_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      index_ff  <= index_in;
   end

endmodule

// ----- rtl/core/sector_run_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
// Allocate scans the 64-sector bitmap rows in order, 1 to 64 of them, until a run fits or
// space runs out, then sets the run in one or two rows; Free checks that the run is set in
// its one or two rows and clears it, else rejects it. One request is in flight at a time;
// the next is accepted in the cycle its result rises on rsp_tvalid, unless the result waits;
// the row scan sets the pace. Reset is synchronous; a clearing pass over all 64 rows then
// marks every sector free before the first request is taken; device_sectors resets to 4096.

module sector_run_bitmap_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // free_index[11:0], zero fill
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], sector_index[13:2], zero fill
);
   import sra_pkg::*;

   logic [DEV_W-1:0]  device_ff;
   logic [LIM_W-1:0]  dev_ext;
   logic [LIM_W-1:0]  limit;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              slot_free;
   result_type        result;
   ram_req_type       ram_req;
   logic [WORD_W-1:0] rd_data;

   assign dev_ext   = LIM_W'(device_ff);
   assign limit     = (dev_ext < LIM_W'(NUM_SECTORS)) ? dev_ext : LIM_W'(NUM_SECTORS);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_ff    <= DEV_W'(4096);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            device_ff <= csr_wdata;
         end
         if (result.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_index_ff  <= result.index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_status_ff};

   sra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit),
      .req_valid (req_tvalid),
      .req_func  (req_tuser[0]),
      .req_index (req_tdata[IDX_W-1:0]),
      .req_ready (req_tready),
      .slot_free (slot_free),
      .result    (result),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   sra_bitmap_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// ----- tb/sector_run_bitmap_allocator_top_test.sv -----
`timescale 1ns / 1ps

module sector_run_bitmap_allocator_top_test;
   import sra_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  index;
   } sector_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [12:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   bit               sector_used [NUM_SECTORS];
   logic [12:0]      model_dev_sectors = 13'd4096;
   sector_reply_type pending_replies [$];
   sector_reply_type head_reply;
   int               live_runs [$];
   bit               steady = 1'b0;
   int               error_count = 0;
   int               alloc_ok_count = 0;
   int               alloc_full_count = 0;
   int               free_ok_count = 0;
   int               free_bad_count = 0;

   sector_run_bitmap_allocator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, actual status %0d index %0d",
                     $time, rsp_tdata[1:0], rsp_tdata[13:2]);
         end else begin
            head_reply = pending_replies.pop_front();
            if (rsp_tdata[1:0] !== head_reply.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, head_reply.status, rsp_tdata[1:0]);
            end
            if (rsp_tdata[13:2] !== head_reply.index) begin
               error_count++;
               $display("%0t: sector_index mismatch, expected %0d, actual %0d",
                        $time, head_reply.index, rsp_tdata[13:2]);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("sector_run_bitmap_allocator_top regression: fail");
      $finish;
   end

   function automatic int usable_sectors();
      return (int'(model_dev_sectors) < NUM_SECTORS) ? int'(model_dev_sectors) : NUM_SECTORS;
   endfunction

   function automatic sector_reply_type predict_reply(input logic func,
                                                      input logic [IDX_W-1:0] idx);
      sector_reply_type reply;
      int               limit;
      bit               fits;
      reply.status = ST_OK;
      reply.index  = '0;
      limit = usable_sectors();
      if (func == FUNC_ALLOC) begin
         for (int s = 0; s + RUN_LENGTH <= limit; s++) begin
            fits = 1'b1;
            for (int k = 0; k < RUN_LENGTH; k++) begin
               if (sector_used[s + k]) fits = 1'b0;
            end
            if (fits) begin
               for (int k = 0; k < RUN_LENGTH; k++) sector_used[s + k] = 1'b1;
               reply.index = s[IDX_W-1:0];
               live_runs.push_back(s);
               alloc_ok_count++;
               return reply;
            end
         end
         reply.status = ST_NO_SPACE;
         alloc_full_count++;
         return reply;
      end
      fits = (int'(idx) + RUN_LENGTH <= limit);
      if (fits) begin
         for (int k = 0; k < RUN_LENGTH; k++) begin
            if (!sector_used[int'(idx) + k]) fits = 1'b0;
         end
      end
      if (!fits) begin
         reply.status = ST_BAD_RUN;
         free_bad_count++;
         return reply;
      end
      for (int k = 0; k < RUN_LENGTH; k++) sector_used[int'(idx) + k] = 1'b0;
      free_ok_count++;
      return reply;
   endfunction

   function automatic int take_live_run();
      int slot;
      int start;
      slot  = $urandom_range(0, live_runs.size() - 1);
      start = live_runs[slot];
      live_runs.delete(slot);
      return start;
   endfunction

   task automatic send_request(input logic func, input logic [IDX_W-1:0] idx);
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(16 - IDX_W){1'b0}}, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(predict_reply(func, idx));
   endtask

   task automatic finish_outstanding();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_device_sectors(input logic [12:0] value);
      finish_outstanding();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_dev_sectors = value;
   endtask

   task automatic test_basic_operations();
      write_device_sectors(13'd4096);
      send_request(FUNC_ALLOC, 12'hfff);
      send_request(FUNC_ALLOC, 12'h000);
      send_request(FUNC_FREE, 12'd0);
      send_request(FUNC_FREE, 12'd0);
      send_request(FUNC_ALLOC, 12'h5a5);
      send_request(FUNC_FREE, 12'd4095);
      send_request(FUNC_FREE, 12'd4088);
      send_request(FUNC_FREE, 12'd4);
      send_request(FUNC_ALLOC, 12'h000);
   endtask

   task automatic test_device_limits();
      write_device_sectors(13'd16);
      send_request(FUNC_ALLOC, 12'h000);
      write_device_sectors(13'd0);
      send_request(FUNC_ALLOC, 12'h000);
      send_request(FUNC_FREE, 12'd0);
      write_device_sectors(13'h1fff);
      send_request(FUNC_ALLOC, 12'h000);
      write_device_sectors(13'd7);
      send_request(FUNC_ALLOC, 12'h000);
      write_device_sectors(13'd8);
      send_request(FUNC_ALLOC, 12'h000);
   endtask

   task automatic test_device_shrink();
      int last_run;
      write_device_sectors(13'd48);
      send_request(FUNC_ALLOC, 12'h000);
      send_request(FUNC_ALLOC, 12'h000);
      send_request(FUNC_ALLOC, 12'h000);
      finish_outstanding();
      last_run = live_runs[$];
      write_device_sectors(13'd16);
      send_request(FUNC_FREE, last_run[IDX_W-1:0]);
      send_request(FUNC_ALLOC, 12'h000);
      write_device_sectors(13'd48);
      send_request(FUNC_FREE, last_run[IDX_W-1:0]);
   endtask

   task automatic send_random_request(input int alloc_pct);
      int               pick;
      int               v;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      v    = $urandom_range(0, NUM_SECTORS - 1);
      idx  = v[IDX_W-1:0];
      if (pick < alloc_pct) begin
         send_request(FUNC_ALLOC, idx);
      end else if (pick < alloc_pct + (100 - alloc_pct) * 2 / 3 && live_runs.size() != 0) begin
         v = take_live_run();
         send_request(FUNC_FREE, v[IDX_W-1:0]);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
            end
            1: begin
               if (live_runs.size() != 0) begin
                  v = live_runs[$urandom_range(0, live_runs.size() - 1)]
                      + $urandom_range(0, 14) - 7;
                  idx = v[IDX_W-1:0];
               end
            end
            default: begin
               v   = usable_sectors() - $urandom_range(0, 15);
               idx = v[IDX_W-1:0];
            end
         endcase
         send_request(FUNC_FREE, idx);
      end
   endtask

   task automatic test_random_traffic();
      logic [12:0] dev_value;
      int          item_total;
      int          alloc_pct;
      for (int phase = 0; phase < 8; phase++) begin
         item_total = 180;
         alloc_pct  = 55;
         case (phase)
            0: dev_value = 13'd4096;
            1: dev_value = 13'h1fff;
            2: dev_value = 13'($urandom_range(8, 160));
            3: dev_value = 13'($urandom_range(0, 8191));
            4: begin
               dev_value  = 13'd4096;
               item_total = 340;
               alloc_pct  = 90;
            end
            5: begin
               dev_value = 13'($urandom_range(9, 64));
               alloc_pct = 50;
            end
            6: dev_value = 13'd4100;
            default: dev_value = 13'd4095;
         endcase
         write_device_sectors(dev_value);
         steady = (phase == 1);
         for (int n = 0; n < item_total; n++) begin
            if (phase == 2 && n == 90) finish_outstanding();
            send_random_request(alloc_pct);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_operations();
      test_device_limits();
      test_device_shrink();
      test_random_traffic();
      finish_outstanding();
      repeat (80) @(posedge clock);
      $display("Allocations: %0d granted, %0d refused for lack of space.",
               alloc_ok_count, alloc_full_count);
      $display("Frees: %0d accepted, %0d rejected; device sizes from 0 to 8191 sectors.",
               free_ok_count, free_bad_count);
      if (error_count == 0) begin
         $display("sector_run_bitmap_allocator_top regression: pass");
      end else begin
         $display("sector_run_bitmap_allocator_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sra_pkg.sv
rtl/core/sra_bitmap_ram.sv
rtl/core/sra_ctrl.sv
rtl/core/sector_run_bitmap_allocator_top.sv
tb/sector_run_bitmap_allocator_top_test.sv
